FILE: src/gas_pkg.sv
package gas_pkg;

   localparam int SCORE_W = 20;
   localparam int GAP_W   = 8;
   localparam int SYM_W   = 5;
   localparam int ENTRY_W = 8;
   localparam int INDEX_W = 7;

   localparam logic [1:0] KIND_TABLE = 2'd0;
   localparam logic [1:0] KIND_ROW   = 2'd1;
   localparam logic [1:0] KIND_COL   = 2'd2;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MIRROR,
      ST_RUN,
      ST_DRAIN
   } state_type;

   typedef struct packed {
      logic                      vld;
      logic                      init;
      logic signed [SCORE_W-1:0] diag;
      logic signed [SCORE_W-1:0] up;
      logic signed [SCORE_W-1:0] ibase;
   } token_type;

   typedef struct packed {
      logic                      live;
      logic signed [ENTRY_W-1:0] score;
   } bus_type;

endpackage

FILE: src/gas_ram.sv
module gas_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [0:DEPTH-1];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: src/gas_cell.sv
module gas_cell (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [gas_pkg::GAP_W-1:0]    gap,
   input  gas_pkg::bus_type             bus,
   input  gas_pkg::token_type           up_tok,
   output gas_pkg::token_type           down_tok
);
   import gas_pkg::*;

   localparam logic signed [SCORE_W:0] SAT_HI = {2'b00, {(SCORE_W-1){1'b1}}};
   localparam logic signed [SCORE_W:0] SAT_LO = {2'b11, {(SCORE_W-1){1'b0}}};

   logic signed [SCORE_W-1:0] val_ff, val_in;
   logic signed [SCORE_W-1:0] ival, cur, best_sat;
   logic signed [SCORE_W:0]   gap_x, del_cost, ins_cost, sub_cost, best;
   logic                      update;
   token_type                 tok_ff, tok_in;

   always_comb begin
      gap_x    = {{(SCORE_W+1-GAP_W){1'b0}}, gap};
      ival     = SCORE_W'({up_tok.ibase[SCORE_W-1], up_tok.ibase} - gap_x);
      cur      = up_tok.init ? ival : val_ff;
      del_cost = {cur[SCORE_W-1], cur} - gap_x;
      ins_cost = {up_tok.up[SCORE_W-1], up_tok.up} - gap_x;
      sub_cost = {up_tok.diag[SCORE_W-1], up_tok.diag}
               + {{(SCORE_W+1-ENTRY_W){bus.score[ENTRY_W-1]}}, bus.score};
      best = del_cost;
      if (ins_cost > best) begin
         best = ins_cost;
      end
      if (sub_cost > best) begin
         best = sub_cost;
      end
      if (best > SAT_HI) begin
         best_sat = SAT_HI[SCORE_W-1:0];
      end else if (best < SAT_LO) begin
         best_sat = SAT_LO[SCORE_W-1:0];
      end else begin
         best_sat = best[SCORE_W-1:0];
      end
      update       = up_tok.vld && bus.live;
      val_in       = update ? best_sat : val_ff;
      tok_in.vld   = up_tok.vld;
      tok_in.init  = up_tok.init;
      tok_in.diag  = cur;
      tok_in.up    = update ? best_sat : up_tok.up;
      tok_in.ibase = ival;
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in;
      end
   end

   assign down_tok = tok_ff;

endmodule

FILE: src/gas_chain.sv
module gas_chain #(
   parameter int MAX_LEN = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [gas_pkg::GAP_W-1:0] gap,
   input  gas_pkg::bus_type          bus,
   input  gas_pkg::token_type        head,
   output gas_pkg::token_type        tail
);
   import gas_pkg::*;

   token_type tok [0:MAX_LEN];

   assign tok[0] = head;

   for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
      gas_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .gap      (gap),
         .bus      (bus),
         .up_tok   (tok[i]),
         .down_tok (tok[i+1])
      );
   end

   assign tail = tok[MAX_LEN];

endmodule

FILE: src/global_alignment_score_top.sv
// column word: result set by the token walking the cell chain
// next word accepted once the result word has been taken; no new column while one runs
// table word: both mirror entries written through one write port, the second from the mirror state; row word: one write
// synchronous reset: gap_penalty back to 4, counts cleared, then a table clearing pass over all
// 2**(2*clog2(ALPHABET)) entries (1024 at the defaults) with req_tready low
module global_alignment_score_top #(
   parameter int MAX_LEN  = 64,
   parameter int ALPHABET = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // row_symbol, col_symbol, entry_value
   input  logic [2:0]  req_tuser,   // kind, first
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // column_index, column_score
   input  logic        csr_we,
   input  logic [7:0]  csr_wdata
);
   import gas_pkg::*;

   localparam int AW     = $clog2(ALPHABET);
   localparam int TAW    = 2 * AW;
   localparam int TDEPTH = 1 << TAW;
   localparam int LW     = $clog2(MAX_LEN);
   localparam int CW     = $clog2(MAX_LEN + 1);
   localparam int PW     = GAP_W + CW;

   state_type state_ff, state_in;

   logic [TAW-1:0]            clr_ff, clr_in;
   logic [GAP_W-1:0]          gap_ff, gap_in;
   logic [CW-1:0]             row_count_ff, row_count_in;
   logic [CW-1:0]             col_count_ff, col_count_in;
   logic [CW-1:0]             j_ff, j_in;
   logic                      pass_ff, pass_in;
   logic [SYM_W-1:0]          cs_ff, cs_in;
   logic [TAW-1:0]            mir_addr_ff, mir_addr_in;
   logic [ENTRY_W-1:0]        mir_val_ff, mir_val_in;
   logic [LW-1:0]             mcnt_ff, mcnt_in;
   logic signed [SCORE_W-1:0] col0_ff, col0_in;
   logic                      lau_vld_ff, lau_vld_in;
   logic                      lau_init_ff, lau_init_in;
   logic signed [SCORE_W-1:0] lau_diag_ff, lau_diag_in;
   token_type                 tok0_ff, tok0_in;
   logic                      live_a_ff, live_a_in;
   logic                      live_b_ff, live_b_in;
   logic                      symok_b_ff, symok_b_in;
   logic                      rsp_vld_ff, rsp_vld_in;
   logic [INDEX_W-1:0]        rsp_idx_ff, rsp_idx_in;
   logic signed [SCORE_W-1:0] rsp_score_ff, rsp_score_in;

   logic [1:0]                kind;
   logic                      first;
   logic [SYM_W-1:0]          rs, cs;
   logic [ENTRY_W-1:0]        ev;
   logic                      req_fire, rs_ok, cs_ok;
   logic [CW-1:0]             rc_eff, cc_eff;
   logic [PW-1:0]             prod;
   logic signed [SCORE_W-1:0] col_up;

   logic                      tbl_we;
   logic [TAW-1:0]            tbl_waddr, tbl_raddr;
   logic [ENTRY_W-1:0]        tbl_wdata, tbl_rdata;
   logic                      row_we;
   logic [LW-1:0]             row_waddr, row_raddr;
   logic [SYM_W-1:0]          row_wdata, row_rdata;

   bus_type                   bus;
   token_type                 tail;

   assign kind   = req_tuser[1:0];
   assign first  = req_tuser[2];
   assign rs     = req_tdata[4:0];
   assign cs     = req_tdata[9:5];
   assign ev     = req_tdata[17:10];

   assign req_tready = (state_ff == ST_IDLE) && !rsp_vld_ff;
   assign req_fire   = req_tvalid && req_tready;
   assign rs_ok      = int'(rs) < ALPHABET;
   assign cs_ok      = int'(cs) < ALPHABET;
   assign rc_eff     = first ? '0 : row_count_ff;
   assign cc_eff     = first ? '0 : col_count_ff;

   assign prod   = PW'(gap_ff) * PW'(j_ff);
   assign col_up = '0 - SCORE_W'(prod);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (&clr_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               case (kind)
                  KIND_TABLE: begin
                     if (rs_ok && cs_ok) begin
                        state_in = ST_MIRROR;
                     end
                  end
                  KIND_COL: begin
                     if (cc_eff < CW'(MAX_LEN)) begin
                        state_in = ST_RUN;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_MIRROR: state_in = ST_IDLE;
         ST_RUN: begin
            if (mcnt_ff == LW'(MAX_LEN - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (tail.vld) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      clr_in       = clr_ff;
      gap_in       = csr_we ? csr_wdata : gap_ff;
      row_count_in = row_count_ff;
      col_count_in = col_count_ff;
      j_in         = j_ff;
      pass_in      = pass_ff;
      cs_in        = cs_ff;
      mir_addr_in  = mir_addr_ff;
      mir_val_in   = mir_val_ff;
      mcnt_in      = mcnt_ff;
      rsp_vld_in   = rsp_vld_ff && !rsp_tready;
      rsp_idx_in   = rsp_idx_ff;
      rsp_score_in = rsp_score_ff;
      tbl_we       = 1'b0;
      tbl_waddr    = clr_ff;
      tbl_wdata    = '0;
      row_we       = 1'b0;
      row_waddr    = LW'(rc_eff);
      row_wdata    = rs;
      case (state_ff)
         ST_CLEAR: begin
            tbl_we = 1'b1;
            clr_in = clr_ff + 1'b1;
         end
         ST_IDLE: begin
            if (req_fire) begin
               case (kind)
                  KIND_TABLE: begin
                     if (rs_ok && cs_ok) begin
                        tbl_we      = 1'b1;
                        tbl_waddr   = {AW'(rs), AW'(cs)};
                        tbl_wdata   = ev;
                        mir_addr_in = {AW'(cs), AW'(rs)};
                        mir_val_in  = ev;
                     end
                  end
                  KIND_ROW: begin
                     col_count_in = '0;
                     if (rc_eff < CW'(MAX_LEN)) begin
                        row_we       = 1'b1;
                        row_count_in = rc_eff + 1'b1;
                     end else begin
                        row_count_in = rc_eff;
                     end
                  end
                  KIND_COL: begin
                     col_count_in = cc_eff;
                     if (cc_eff < CW'(MAX_LEN)) begin
                        col_count_in = cc_eff + 1'b1;
                        j_in         = cc_eff + 1'b1;
                        pass_in      = (cc_eff == '0);
                        cs_in        = cs;
                        mcnt_in      = '0;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_MIRROR: begin
            tbl_we    = 1'b1;
            tbl_waddr = mir_addr_ff;
            tbl_wdata = mir_val_ff;
         end
         ST_RUN: begin
            mcnt_in = mcnt_ff + 1'b1;
         end
         ST_DRAIN: begin
            if (tail.vld) begin
               rsp_vld_in   = 1'b1;
               rsp_idx_in   = INDEX_W'(j_ff);
               rsp_score_in = tail.up;
            end
         end
         default: ;
      endcase
   end

   // lookup pipeline and token launch
   always_comb begin
      row_raddr     = mcnt_ff;
      live_a_in     = (state_ff == ST_RUN) && (CW'(mcnt_ff) < row_count_ff);
      live_b_in     = live_a_ff;
      tbl_raddr     = {AW'(row_rdata), AW'(cs_ff)};
      symok_b_in    = (int'(row_rdata) < ALPHABET) && (int'(cs_ff) < ALPHABET);
      lau_vld_in    = (state_ff == ST_RUN) && (mcnt_ff == '0);
      lau_init_in   = pass_ff;
      lau_diag_in   = pass_ff ? '0 : col0_ff;
      tok0_in.vld   = lau_vld_ff;
      tok0_in.init  = lau_init_ff;
      tok0_in.diag  = lau_diag_ff;
      tok0_in.up    = col_up;
      tok0_in.ibase = '0;
      col0_in       = lau_vld_ff ? col_up : col0_ff;
      bus.live      = live_b_ff;
      bus.score     = symok_b_ff ? tbl_rdata : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         gap_ff       <= GAP_W'(4);
         row_count_ff <= '0;
         col_count_ff <= '0;
         lau_vld_ff   <= 1'b0;
         tok0_ff      <= '0;
         live_a_ff    <= 1'b0;
         live_b_ff    <= 1'b0;
         rsp_vld_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         gap_ff       <= gap_in;
         row_count_ff <= row_count_in;
         col_count_ff <= col_count_in;
         lau_vld_ff   <= lau_vld_in;
         tok0_ff      <= tok0_in;
         live_a_ff    <= live_a_in;
         live_b_ff    <= live_b_in;
         rsp_vld_ff   <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      j_ff         <= j_in;
      pass_ff      <= pass_in;
      cs_ff        <= cs_in;
      mir_addr_ff  <= mir_addr_in;
      mir_val_ff   <= mir_val_in;
      mcnt_ff      <= mcnt_in;
      col0_ff      <= col0_in;
      lau_init_ff  <= lau_init_in;
      lau_diag_ff  <= lau_diag_in;
      symok_b_ff   <= symok_b_in;
      rsp_idx_ff   <= rsp_idx_in;
      rsp_score_ff <= rsp_score_in;
   end

   gas_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TDEPTH)
   ) u_table (
      .clock (clock),
      .we    (tbl_we),
      .waddr (tbl_waddr),
      .wdata (tbl_wdata),
      .raddr (tbl_raddr),
      .rdata (tbl_rdata)
   );

   gas_ram #(
      .WIDTH (SYM_W),
      .DEPTH (MAX_LEN)
   ) u_rows (
      .clock (clock),
      .we    (row_we),
      .waddr (row_waddr),
      .wdata (row_wdata),
      .raddr (row_raddr),
      .rdata (row_rdata)
   );

   gas_chain #(
      .MAX_LEN (MAX_LEN)
   ) u_chain (
      .clock (clock),
      .reset (reset),
      .gap   (gap_ff),
      .bus   (bus),
      .head  (tok0_ff),
      .tail  (tail)
   );

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {5'd0, rsp_score_ff, rsp_idx_ff};

   a_no_rsp_in_run: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> !rsp_vld_ff)
      else $error("result word pending while a column runs");

   a_tail_in_drain: assert property (@(posedge clock) disable iff (reset)
      tail.vld |-> (state_ff == ST_DRAIN))
      else $error("chain token left outside drain");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      (row_count_ff <= CW'(MAX_LEN)) && (col_count_ff <= CW'(MAX_LEN)))
      else $error("row or column count beyond length");

endmodule

FILE: tb/sv/alignment_checker.sv
module alignment_checker #(
   parameter int MAX_LEN  = 64,
   parameter int ALPHABET = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [23:0] req_tdata,   // row_symbol, col_symbol, entry_value
   input  logic [2:0]  req_tuser,   // kind, first
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,   // column_index, column_score
   input  logic        csr_we,
   input  logic [7:0]  csr_wdata,
   output int          pending_words,
   output int          fail_count
);
   import gas_pkg::*;

   localparam logic [GAP_W-1:0] GAP_RESET = 8'd4;
   localparam int SCORE_HI = 2 ** (SCORE_W - 1) - 1;
   localparam int SCORE_LO = -(2 ** (SCORE_W - 1));

   typedef struct packed {
      logic [INDEX_W-1:0]        col_index;
      logic signed [SCORE_W-1:0] col_score;
   } column_word_type;

   logic signed [ENTRY_W-1:0] score_tbl [ALPHABET][ALPHABET];
   logic [SYM_W-1:0]          row_seq [MAX_LEN];
   logic signed [SCORE_W-1:0] dp_col [MAX_LEN+1];
   int unsigned               row_len;
   int unsigned               col_pos;
   logic [GAP_W-1:0]          gap_cost;
   column_word_type           expected_cols [$];
   int                        mismatches = 0;

   function automatic logic signed [SCORE_W-1:0] clamp_score(input int v);
      if (v > SCORE_HI) return SCORE_W'(SCORE_HI);
      if (v < SCORE_LO) return SCORE_W'(SCORE_LO);
      return SCORE_W'(v);
   endfunction

   function automatic int table_score(input logic [SYM_W-1:0] r, input logic [SYM_W-1:0] c);
      if (r >= ALPHABET || c >= ALPHABET) return 0;
      return int'(score_tbl[r][c]);
   endfunction

   // advance the stored dp column by one column symbol
   function automatic column_word_type next_column(input logic [SYM_W-1:0] sym);
      int cost;
      int j;
      int diag;
      int up;
      int cur;
      int best;
      column_word_type res;
      cost = int'(gap_cost);
      if (col_pos == 0) begin
         for (int i = 0; i <= MAX_LEN; i++) dp_col[i] = clamp_score(-cost * i);
      end
      j = col_pos + 1;
      diag = int'(dp_col[0]);
      up = int'(clamp_score(-cost * j));
      dp_col[0] = SCORE_W'(up);
      for (int i = 1; i <= row_len && i <= MAX_LEN; i++) begin
         cur = int'(dp_col[i]);
         best = cur - cost;
         if (up - cost > best) best = up - cost;
         if (diag + table_score(row_seq[i-1], sym) > best) begin
            best = diag + table_score(row_seq[i-1], sym);
         end
         best = int'(clamp_score(best));
         diag = cur;
         dp_col[i] = SCORE_W'(best);
         up = best;
      end
      col_pos = j;
      res.col_index = INDEX_W'(j);
      res.col_score = SCORE_W'(up);
      return res;
   endfunction

   always @(posedge clock) begin
      column_word_type want;
      column_word_type got;
      logic [1:0] kind;
      logic [SYM_W-1:0] rs;
      logic [SYM_W-1:0] cs;
      logic signed [ENTRY_W-1:0] ev;
      logic fst;
      if (reset) begin
         for (int r = 0; r < ALPHABET; r++) begin
            for (int c = 0; c < ALPHABET; c++) score_tbl[r][c] = '0;
         end
         row_len = 0;
         col_pos = 0;
         gap_cost = GAP_RESET;
         expected_cols.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.col_index = rsp_tdata[INDEX_W-1:0];
            got.col_score = rsp_tdata[INDEX_W+SCORE_W-1:INDEX_W];
            if (expected_cols.size() == 0) begin
               mismatches++;
               $error("unexpected column word: index %0d score %0d",
                      got.col_index, got.col_score);
            end else begin
               want = expected_cols.pop_front();
               if (got.col_index !== want.col_index) begin
                  mismatches++;
                  $error("column_index mismatch: expected %0d, actual %0d",
                         want.col_index, got.col_index);
               end
               if (got.col_score !== want.col_score) begin
                  mismatches++;
                  $error("column_score mismatch: expected %0d, actual %0d",
                         want.col_score, got.col_score);
               end
            end
         end
         if (csr_we) gap_cost = csr_wdata;
         if (req_tvalid && req_tready) begin
            rs   = req_tdata[SYM_W-1:0];
            cs   = req_tdata[2*SYM_W-1:SYM_W];
            ev   = req_tdata[2*SYM_W+ENTRY_W-1:2*SYM_W];
            kind = req_tuser[1:0];
            fst  = req_tuser[2];
            case (kind)
               KIND_TABLE: begin
                  if (rs < ALPHABET && cs < ALPHABET) begin
                     score_tbl[rs][cs] = ev;
                     score_tbl[cs][rs] = ev;
                  end
               end
               KIND_ROW: begin
                  if (fst) row_len = 0;
                  col_pos = 0;
                  if (row_len < MAX_LEN) begin
                     row_seq[row_len] = rs;
                     row_len++;
                  end
               end
               KIND_COL: begin
                  if (fst) col_pos = 0;
                  if (col_pos < MAX_LEN) expected_cols.push_back(next_column(cs));
               end
               default: ;
            endcase
         end
      end
      fail_count <= mismatches;
      pending_words <= expected_cols.size();
   end

endmodule

FILE: tb/sv/tb_top.sv
module tb_top;
   import gas_pkg::*;

   localparam int MAX_LEN     = 64;
   localparam int ALPHABET    = 32;
   localparam int ITEM_TARGET = 1050;
   localparam int SETTLE      = MAX_LEN + 8;
   localparam logic [1:0] KIND_NONE = 2'd3;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;   // row_symbol, col_symbol, entry_value
   logic [2:0]  req_tuser = '0;   // kind, first
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // column_index, column_score
   logic        csr_we = 1'b0;
   logic [7:0]  csr_wdata = '0;

   int pending_words;
   int fail_count;
   int items_sent = 0;
   bit send_calm = 1'b0;
   bit hold_request = 1'b0;

   always #5 clock = ~clock;

   global_alignment_score_top #(
      .MAX_LEN  (MAX_LEN),
      .ALPHABET (ALPHABET)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   alignment_checker #(
      .MAX_LEN  (MAX_LEN),
      .ALPHABET (ALPHABET)
   ) checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .csr_we        (csr_we),
      .csr_wdata     (csr_wdata),
      .pending_words (pending_words),
      .fail_count    (fail_count)
   );

   initial begin
      #5_000_000;
      $display("** global_alignment_score_top: FAILED **");
      $finish;
   end

   // result side: random stalls, calm stretches, long hold on request
   initial begin : receiver
      int stall;
      int taken;
      bit calm;
      taken = 0;
      calm = 1'b0;
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_tready <= 1'b0;
            repeat (600) @(posedge clock);
         end
         stall = calm ? 0 : $urandom_range(0, 15);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         taken++;
         if (taken % 32 == 0) calm = ($urandom_range(0, 3) == 0);
      end
   end

   function automatic logic [SYM_W-1:0] pick_sym();
      if ($urandom_range(0, 2) == 0) return SYM_W'($urandom_range(0, 31));
      return SYM_W'($urandom_range(0, 3));
   endfunction

   function automatic logic [ENTRY_W-1:0] pick_entry();
      case ($urandom_range(0, 5))
         0: return 8'h7f;
         1: return 8'h80;
         default: return ENTRY_W'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [GAP_W-1:0] pick_gap();
      case ($urandom_range(0, 5))
         0: return 8'd0;
         1: return 8'd255;
         default: return GAP_W'($urandom_range(0, 20));
      endcase
   endfunction

   task automatic send_word(input logic [1:0] kind, input logic [SYM_W-1:0] rs,
                            input logic [SYM_W-1:0] cs, input logic [ENTRY_W-1:0] ev,
                            input logic fst);
      int idle;
      idle = send_calm ? 0 : $urandom_range(0, 15);
      if (idle > 0) begin
         req_tvalid <= 1'b0;
         repeat (idle) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'd0, ev, cs, rs};
      req_tuser  <= {fst, kind};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (kind != KIND_NONE) items_sent++;
      if (items_sent % 40 == 0) send_calm = ($urandom_range(0, 3) == 0);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_words != 0) @(posedge clock);
   endtask

   task automatic set_gap(input logic [GAP_W-1:0] g);
      drain_results();
      repeat (SETTLE) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= g;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic write_table(input int n);
      for (int k = 0; k < n; k++) begin
         send_word(KIND_TABLE, pick_sym(), pick_sym(), pick_entry(),
                   1'($urandom_range(0, 1)));
      end
   endtask

   task automatic load_row(input int n, input logic fst_first);
      for (int k = 0; k < n; k++) begin
         send_word(KIND_ROW, pick_sym(), SYM_W'($urandom_range(0, 31)),
                   ENTRY_W'($urandom_range(0, 255)),
                   (k == 0) ? fst_first : ($urandom_range(0, 29) == 0));
      end
   endtask

   task automatic stream_cols(input int n, input logic fst_first);
      for (int k = 0; k < n; k++) begin
         send_word(KIND_COL, SYM_W'($urandom_range(0, 31)), pick_sym(),
                   ENTRY_W'($urandom_range(0, 255)),
                   (k == 0) ? fst_first : ($urandom_range(0, 19) == 0));
      end
   endtask

   initial begin : stimulus
      int phase;
      int row_n;
      int col_n;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // empty row sequence, reset gap
      send_word(KIND_COL, 5'd0, 5'd0, 8'h00, 1'b1);
      send_word(KIND_COL, 5'd31, 5'd31, 8'hff, 1'b0);
      send_word(KIND_NONE, 5'd31, 5'd31, 8'hff, 1'b1);
      send_word(KIND_TABLE, 5'd0, 5'd0, 8'h7f, 1'b0);
      send_word(KIND_TABLE, 5'd31, 5'd31, 8'h80, 1'b1);
      send_word(KIND_TABLE, 5'd0, 5'd31, 8'h05, 1'b0);
      send_word(KIND_TABLE, 5'd17, 5'd3, 8'hf9, 1'b0);
      send_word(KIND_ROW, 5'd0, 5'd0, 8'h00, 1'b1);
      send_word(KIND_ROW, 5'd31, 5'd31, 8'hff, 1'b0);
      send_word(KIND_ROW, 5'd3, 5'd0, 8'h00, 1'b0);
      send_word(KIND_COL, 5'd0, 5'd0, 8'h00, 1'b1);
      send_word(KIND_COL, 5'd0, 5'd31, 8'h00, 1'b0);
      send_word(KIND_COL, 5'd0, 5'd17, 8'h00, 1'b0);
      // restart mid pass, then append to row which ends the pass
      send_word(KIND_COL, 5'd0, 5'd31, 8'h00, 1'b1);
      send_word(KIND_ROW, 5'd0, 5'd0, 8'h00, 1'b0);
      send_word(KIND_COL, 5'd0, 5'd0, 8'h00, 1'b0);
      send_word(KIND_COL, 5'd0, 5'd3, 8'h00, 1'b0);
      set_gap(8'd0);
      send_word(KIND_COL, 5'd0, 5'd0, 8'h00, 1'b1);
      send_word(KIND_COL, 5'd0, 5'd31, 8'h00, 1'b0);
      set_gap(8'd255);
      send_word(KIND_COL, 5'd0, 5'd31, 8'h00, 1'b1);
      send_word(KIND_COL, 5'd0, 5'd0, 8'h00, 1'b0);

      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         phase++;
         if (phase == 1 || $urandom_range(0, 5) == 0) set_gap(pick_gap());
         if (phase == 4 || phase == 40) begin
            drain_results();
            hold_request = 1'b1;
            stream_cols(8, 1'b1);
         end
         write_table($urandom_range(0, 6));
         if (phase == 2) row_n = MAX_LEN + 3;
         else if ($urandom_range(0, 14) == 0) row_n = $urandom_range(MAX_LEN - 4, MAX_LEN + 6);
         else if ($urandom_range(0, 7) == 0) row_n = 0;
         else row_n = $urandom_range(1, 8);
         load_row(row_n, $urandom_range(0, 9) != 0);
         if (phase == 2) col_n = MAX_LEN + 3;
         else if ($urandom_range(0, 14) == 0) col_n = $urandom_range(MAX_LEN - 4, MAX_LEN + 6);
         else col_n = $urandom_range(1, 10);
         stream_cols(col_n, $urandom_range(0, 7) != 0);
         if ($urandom_range(0, 7) == 0) begin
            send_word(KIND_NONE, SYM_W'($urandom_range(0, 31)), SYM_W'($urandom_range(0, 31)),
                      ENTRY_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
         end
      end

      drain_results();
      repeat (SETTLE) @(posedge clock);
      if (fail_count == 0) begin
         $display("** global_alignment_score_top: PASSED **");
      end else begin
         $display("** global_alignment_score_top: FAILED **");
      end
      $finish;
   end

endmodule

FILE: filelist.f
src/gas_pkg.sv
src/gas_ram.sv
src/gas_cell.sv
src/gas_chain.sv
src/global_alignment_score_top.sv
tb/sv/alignment_checker.sv
tb/sv/tb_top.sv
